[hdl/lhvp_pkg.sv]
package lhvp_pkg;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_TRUNCATED     = 3'd1,
      ST_OVERFLOW      = 3'd2,
      ST_NON_CANONICAL = 3'd3,
      ST_BAD_VERSION   = 3'd4,
      ST_BAD_DATA_SIZE = 3'd5,
      ST_BAD_ID_SIZE   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PH_VERSION = 4'b0001,
      PH_DATA    = 4'b0010,
      PH_ID      = 4'b0100,
      PH_COUNT   = 4'b1000
   } phase_type;

   localparam logic [63:0] VERSION_SUPPORTED = 64'd1;
   localparam logic [3:0]  VERSION_LAST_IDX  = 4'd7;
   localparam logic [3:0]  VARINT_LAST_IDX   = 4'd9;

   typedef struct packed {
      status_type  status;
      logic [63:0] version_word;
      logic [63:0] payload_size;
      logic [63:0] id_size;
      logic [63:0] entry_count;
      logic [5:0]  consumed;
   } result_type;

endpackage

[hdl/lhvp_req_if.sv]
interface lhvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

[hdl/lhvp_rsp_if.sv]
interface lhvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] version_word;
   logic [63:0] payload_size;
   logic [63:0] id_size;
   logic [63:0] entry_count;
   logic [5:0]  consumed;

   modport source (output valid, output status, output version_word, output payload_size,
                   output id_size, output entry_count, output consumed, input ready);
   modport sink   (input valid, input status, input version_word, input payload_size,
                   input id_size, input entry_count, input consumed, output ready);
endinterface

[hdl/lhvp_core.sv]
module lhvp_core
   import lhvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] byte_value,
   input  logic       last_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] ver_ff, ver_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] dsize_ff, dsize_in;
   logic [63:0] isize_ff, isize_in;
   logic        swallow_ff, swallow_in;

   logic [63:0] acc_new;
   logic [5:0]  shamt;
   logic        done;

   function automatic logic size_ok(input logic [63:0] s);
      size_ok = (s == 64'd1) || (s == 64'd2) || (s == 64'd4) ||
                (s == 64'd8) || (s == 64'd16);
   endfunction

   // 7 * idx, idx never exceeds 9 in varint phases so the result fits 6 bits
   assign shamt   = {idx_ff[2:0], 3'b000} - {2'b00, idx_ff};
   assign acc_new = acc_ff | ({57'd0, byte_value[6:0]} << shamt);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      ver_in     = ver_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      dsize_in   = dsize_ff;
      isize_in   = isize_ff;
      swallow_in = swallow_ff;
      done       = 1'b0;
      res        = '0;
      res.status = ST_OK;

      if (in_accept) begin
         if (swallow_ff) begin
            if (last_byte) begin
               swallow_in = 1'b0;
               phase_in   = PH_VERSION;
               pos_in     = '0;
               ver_in     = '0;
               acc_in     = '0;
               idx_in     = '0;
               dsize_in   = '0;
               isize_in   = '0;
            end
         end else begin
            pos_in = pos_ff + 6'd1;
            case (phase_ff)
               PH_VERSION: begin
                  ver_in = ver_ff | ({56'd0, byte_value} << {idx_ff[2:0], 3'b000});
                  if (idx_ff == VERSION_LAST_IDX) begin
                     idx_in = '0;
                     if (ver_in != VERSION_SUPPORTED) begin
                        done             = 1'b1;
                        res.status       = ST_BAD_VERSION;
                        res.version_word = ver_in;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               default: begin
                  if (idx_ff >= VARINT_LAST_IDX && byte_value >= 8'd2) begin
                     done             = 1'b1;
                     res.status       = ST_OVERFLOW;
                     res.version_word = ver_ff;
                  end else if (idx_ff != 4'd0 && byte_value == 8'd0) begin
                     done             = 1'b1;
                     res.status       = ST_NON_CANONICAL;
                     res.version_word = ver_ff;
                  end else if (byte_value[7] && idx_ff < VARINT_LAST_IDX) begin
                     acc_in = acc_new;
                     idx_in = idx_ff + 4'd1;
                  end else begin
                     acc_in = '0;
                     idx_in = '0;
                     case (phase_ff)
                        PH_DATA: begin
                           dsize_in = acc_new;
                           phase_in = PH_ID;
                        end
                        PH_ID: begin
                           isize_in = acc_new;
                           phase_in = PH_COUNT;
                        end
                        default: begin
                           done             = 1'b1;
                           res.version_word = ver_ff;
                           res.payload_size = dsize_ff;
                           res.id_size      = isize_ff;
                           res.entry_count  = acc_new;
                           if (!size_ok(dsize_ff)) begin
                              res.status = ST_BAD_DATA_SIZE;
                           end else if (!size_ok(isize_ff)) begin
                              res.status = ST_BAD_ID_SIZE;
                           end else begin
                              res.status   = ST_OK;
                              res.consumed = pos_in;
                           end
                        end
                     endcase
                  end
               end
            endcase

            if (!done && last_byte) begin
               done             = 1'b1;
               res              = '0;
               res.status       = ST_TRUNCATED;
               res.version_word = (phase_in == PH_VERSION) ? 64'd0 : ver_in;
            end

            if (done) begin
               swallow_in = !last_byte;
               phase_in   = PH_VERSION;
               pos_in     = '0;
               ver_in     = '0;
               acc_in     = '0;
               idx_in     = '0;
               dsize_in   = '0;
               isize_in   = '0;
            end
         end
      end
   end

   assign res_valid = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_VERSION;
         pos_ff     <= '0;
         ver_ff     <= '0;
         acc_ff     <= '0;
         idx_ff     <= '0;
         dsize_ff   <= '0;
         isize_ff   <= '0;
         swallow_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         ver_ff     <= ver_in;
         acc_ff     <= acc_in;
         idx_ff     <= idx_in;
         dsize_ff   <= dsize_in;
         isize_ff   <= isize_in;
         swallow_ff <= swallow_in;
      end
   end

endmodule

[hdl/lhvp_rsp_buf.sv]
module lhvp_rsp_buf
   import lhvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   result_type main_data_ff, main_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   // push never arrives while the skid slot is occupied
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

[hdl/log_header_varint_parser.sv]
// Log header parser: decodes an 8-byte little-endian version word (must be 1)
// followed by three unsigned LEB128 varints (data size, id size, entry count).
//
// req_chan: one header byte per transaction, last_byte marks the buffer end.
// rsp_chan: one result transaction per buffer: status, version word, the three
//   decoded fields and the header byte count (only when status is ok).
//
// Throughput: one byte per cycle while req_chan.ready is high. Each byte only
//   ORs into an accumulator, so the whole parse step sits between the state
//   registers and the result register.
// Result path: the result of the deciding byte is registered in the output
//   buffer before it shows on rsp_chan.
// After a result, the rest of the buffer is swallowed up to last_byte.
// Stall: results go into a two-slot output buffer; req_chan.ready drops only
//   while both slots hold results, so bytes keep flowing while one waits.
// Reset (synchronous): parser returns to the version phase, buffer empties.
module log_header_varint_parser
   import lhvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lhvp_req_if.sink   req_chan,
   lhvp_rsp_if.source rsp_chan
);

   logic       req_accept;
   logic       res_valid;
   result_type res;
   logic       buf_full;
   result_type rsp_data;

   // ready comes from registers only
   assign req_chan.ready = !buf_full;
   assign req_accept     = req_chan.valid && !buf_full;

   lhvp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .byte_value (req_chan.byte_value),
      .last_byte  (req_chan.last_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   lhvp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.status       = rsp_data.status;
   assign rsp_chan.version_word = rsp_data.version_word;
   assign rsp_chan.payload_size = rsp_data.payload_size;
   assign rsp_chan.id_size      = rsp_data.id_size;
   assign rsp_chan.entry_count  = rsp_data.entry_count;
   assign rsp_chan.consumed     = rsp_data.consumed;

endmodule

[bench/log_header_checker.sv]
// Watches both channels, keeps its own copy of the header parser state and
// checks every result transaction against the oldest expected one.
module log_header_checker
   import lhvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lhvp_req_if         req,
   lhvp_rsp_if         rsp,
   output int unsigned fail_count,
   output int unsigned outstanding,
   output int unsigned results_checked,
   output logic [6:0]  statuses_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // parser copy
   phase_type   stage;
   logic [5:0]  hdr_pos;
   logic [63:0] ver_acc;
   logic [63:0] field_acc;
   logic [3:0]  field_idx;
   logic [63:0] payload_size_q;
   logic [63:0] id_size_q;
   bit          skip_rest;

   result_type  results_due[$];

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      statuses_seen   = '0;
   end

   function automatic void restart_header();
      stage          = PH_VERSION;
      hdr_pos        = '0;
      ver_acc        = '0;
      field_acc      = '0;
      field_idx      = '0;
      payload_size_q = '0;
      id_size_q      = '0;
   endfunction

   function automatic bit legal_field_size(input logic [63:0] v);
      return v == 64'd1 || v == 64'd2 || v == 64'd4 || v == 64'd8 || v == 64'd16;
   endfunction

   function automatic result_type pack_result(input status_type st, input logic [63:0] ver,
                                              input logic [63:0] dsz, input logic [63:0] isz,
                                              input logic [63:0] cnt, input logic [5:0] used);
      result_type r;
      r.status       = st;
      r.version_word = ver;
      r.payload_size = dsz;
      r.id_size      = isz;
      r.entry_count  = cnt;
      r.consumed     = used;
      return r;
   endfunction

   // Advance the parser copy by one byte; fired says a result is due.
   function automatic void decode_byte(input logic [7:0] b, input logic last,
                                       output bit fired, output result_type r);
      logic [3:0]  idx;
      logic [63:0] v;
      status_type  st;
      fired = 1'b0;
      r     = '0;
      if (skip_rest) begin
         if (last) begin
            skip_rest = 1'b0;
            restart_header();
         end
         return;
      end
      hdr_pos = hdr_pos + 6'd1;
      if (stage == PH_VERSION) begin
         ver_acc = ver_acc | (64'(b) << (8 * field_idx[2:0]));
         if (field_idx >= VERSION_LAST_IDX) begin
            field_idx = '0;
            if (ver_acc != VERSION_SUPPORTED) begin
               r     = pack_result(ST_BAD_VERSION, ver_acc, '0, '0, '0, '0);
               fired = 1'b1;
            end else begin
               stage = PH_DATA;
            end
         end else begin
            field_idx = field_idx + 4'd1;
         end
      end else begin
         idx = field_idx;
         if (idx >= VARINT_LAST_IDX && b >= 8'd2) begin
            r     = pack_result(ST_OVERFLOW, ver_acc, '0, '0, '0, '0);
            fired = 1'b1;
         end else if (idx != 0 && b == 8'd0) begin
            r     = pack_result(ST_NON_CANONICAL, ver_acc, '0, '0, '0, '0);
            fired = 1'b1;
         end else begin
            field_acc = field_acc | (64'(b[6:0]) << (7 * idx));
            if (b[7] && idx < VARINT_LAST_IDX) begin
               field_idx = idx + 4'd1;
            end else begin
               v         = field_acc;
               field_acc = '0;
               field_idx = '0;
               case (stage)
                  PH_DATA: begin
                     payload_size_q = v;
                     stage          = PH_ID;
                  end
                  PH_ID: begin
                     id_size_q = v;
                     stage     = PH_COUNT;
                  end
                  default: begin
                     st = ST_OK;
                     if (!legal_field_size(payload_size_q))
                        st = ST_BAD_DATA_SIZE;
                     else if (!legal_field_size(id_size_q))
                        st = ST_BAD_ID_SIZE;
                     r = pack_result(st, ver_acc, payload_size_q, id_size_q, v,
                                     st == ST_OK ? hdr_pos : 6'd0);
                     fired = 1'b1;
                  end
               endcase
            end
         end
      end
      if (!fired && last) begin
         r     = pack_result(ST_TRUNCATED, stage == PH_VERSION ? 64'd0 : ver_acc,
                             '0, '0, '0, '0);
         fired = 1'b1;
      end
      if (fired) begin
         restart_header();
         skip_rest = !last;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] seen);
      if (seen !== want) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch on result %0d: expected %h, got %h",
                     $realtime, name, results_checked, want, seen);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      bit         fired;
      if (reset) begin
         restart_header();
         skip_rest = 1'b0;
         results_due.delete();
      end else begin
         // check first: a byte accepted now cannot produce a result this edge
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (rsp.status <= ST_BAD_ID_SIZE)
               statuses_seen[rsp.status] = 1'b1;
            if (results_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with nothing expected, status %0d",
                           $realtime, rsp.status);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp.status));
               check_field("version_word", want.version_word, rsp.version_word);
               check_field("payload_size", want.payload_size, rsp.payload_size);
               check_field("id_size", want.id_size, rsp.id_size);
               check_field("entry_count", want.entry_count, rsp.entry_count);
               check_field("consumed", 64'(want.consumed), 64'(rsp.consumed));
            end
            results_checked++;
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            decode_byte(req.byte_value, req.last_byte, fired, fresh);
            if (fired)
               results_due.push_back(fresh);
         end
      end
      outstanding = results_due.size();
   end

endmodule

[bench/tb_log_header_varint_parser.sv]
module tb_log_header_varint_parser;
   import lhvp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Random part length and the point after which nobody idles.
   localparam int unsigned RANDOM_BYTES = 700;
   localparam int unsigned CALM_AFTER   = 620;
   // Watchdog limit; leave lots of room.
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // How push_varint lays out a field.
   localparam int VARINT_PLAIN     = 0;  // minimal LEB128
   localparam int VARINT_PADDED    = 1;  // extra zero byte after a continuation
   localparam int VARINT_TEN_BYTES = 2;  // nine continuation bytes, random tenth

   logic clock;
   logic reset;

   lhvp_req_if req_chan();
   lhvp_rsp_if rsp_chan();

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned results_checked;
   logic [6:0]  statuses_seen;

   int unsigned cycles;
   int unsigned bytes_sent;
   int unsigned stall_left;
   bit          calm;

   logic [7:0]  hdr_bytes[$];

   log_header_varint_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   log_header_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .rsp             (rsp_chan),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .statuses_seen   (statuses_seen)
   );

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   // Idle windows alternate with stretches of full rate on both sides.
   function automatic bit idle_window();
      return !calm && (cycles / 150) % 3 != 0;
   endfunction

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
         $display("FAILURE");
         $finish;
      end
   end

   // Result side backpressure: random stall bursts inside idle windows.
   always @(posedge clock) begin
      if (reset || !idle_window()) begin
         rsp_chan.ready <= 1'b1;
         stall_left     <= 0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 9);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // One byte transaction, with an optional idle burst ahead of it.
   task automatic put_byte(input logic [7:0] b, input logic last);
      if (idle_window() && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.byte_value <= b;
      req_chan.last_byte  <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_sent++;
   endtask

   // Sends the staged buffer with last_byte on its final byte.
   task automatic send_buffer();
      foreach (hdr_bytes[k])
         put_byte(hdr_bytes[k], k == hdr_bytes.size() - 1);
      hdr_bytes.delete();
   endtask

   function automatic void push_word(input logic [63:0] w);
      for (int k = 0; k < 8; k++)
         hdr_bytes.push_back(w[8*k +: 8]);
   endfunction

   function automatic void push_varint(input logic [63:0] v, input int form);
      logic [63:0] rest;
      rest = v;
      if (form == VARINT_TEN_BYTES) begin
         // tenth byte spans zero, one, one with continuation, and overflow
         repeat (9) hdr_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
         hdr_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      while (rest > 64'd127) begin
         hdr_bytes.push_back({1'b1, rest[6:0]});
         rest = rest >> 7;
      end
      if (form == VARINT_PADDED) begin
         hdr_bytes.push_back({1'b1, rest[6:0]});
         hdr_bytes.push_back(8'h00);
      end else begin
         hdr_bytes.push_back({1'b0, rest[6:0]});
      end
   endfunction

   // Field values: mostly legal sizes for the two size fields, wide spread otherwise.
   function automatic logic [63:0] pick_field(input bit size_like);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < (size_like ? 75 : 25))
         return 64'd1 << $urandom_range(0, 4);
      if (roll < 82)
         return 64'($urandom_range(0, 300));
      if (roll < 88)
         return '1;
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   // Mostly well-formed headers with random content; the rest is noise,
   // bad versions, cut-short buffers and corrupted bytes.
   task automatic build_random_buffer();
      int unsigned kind;
      int unsigned roll;
      int unsigned n;
      hdr_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         n = $urandom_range(1, 24);
         repeat (n) hdr_bytes.push_back(8'($urandom));
         return;
      end
      if (kind < 16)
         push_word($urandom_range(0, 1) ? {$urandom, $urandom}
                                        : 64'd1 << $urandom_range(1, 63));
      else
         push_word(VERSION_SUPPORTED);
      for (int f = 0; f < 3; f++) begin
         roll = $urandom_range(0, 99);
         push_varint(pick_field(f < 2), roll < 6  ? VARINT_PADDED :
                                        roll < 11 ? VARINT_TEN_BYTES : VARINT_PLAIN);
      end
      if (kind >= 16 && kind < 28) begin
         n = $urandom_range(1, hdr_bytes.size() - 1);
         while (hdr_bytes.size() > n)
            void'(hdr_bytes.pop_back());
      end else if (kind >= 28 && kind < 36) begin
         hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'($urandom);
      end
      // trailing bytes past the header get swallowed
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) hdr_bytes.push_back(8'($urandom));
   endtask

   initial begin
      int unsigned base;
      reset               = 1'b1;
      calm                = 1'b0;
      cycles              = 0;
      bytes_sent          = 0;
      stall_left          = 0;
      req_chan.valid      = 1'b0;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte  = 1'b0;
      rsp_chan.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // buffer ends on its very first byte
      hdr_bytes = '{8'h00};
      send_buffer();
      // all-ones version word, trailing byte swallowed
      push_word('1);
      hdr_bytes.push_back(8'hA5);
      send_buffer();
      // version 1 in the wrong byte lane
      push_word(64'h100);
      send_buffer();
      // good header, result lands on the last byte
      push_word(VERSION_SUPPORTED);
      push_varint(64'd8, VARINT_PLAIN);
      push_varint(64'd16, VARINT_PLAIN);
      push_varint(64'd0, VARINT_PLAIN);
      send_buffer();
      // widest count field (ten bytes), then trailing bytes
      push_word(VERSION_SUPPORTED);
      push_varint(64'd1, VARINT_PLAIN);
      push_varint(64'd2, VARINT_PLAIN);
      push_varint('1, VARINT_PLAIN);
      hdr_bytes.push_back(8'h00);
      hdr_bytes.push_back(8'hFF);
      send_buffer();
      // tenth data byte of 2 with continuation bit: overflow
      push_word(VERSION_SUPPORTED);
      repeat (9) hdr_bytes.push_back(8'h80);
      hdr_bytes.push_back(8'h82);
      send_buffer();
      // tenth id byte of zero: non-canonical
      push_word(VERSION_SUPPORTED);
      push_varint(64'd4, VARINT_PLAIN);
      repeat (9) hdr_bytes.push_back(8'hFF);
      hdr_bytes.push_back(8'h00);
      hdr_bytes.push_back(8'h7E);
      send_buffer();
      // zero final byte right after a continuation byte
      push_word(VERSION_SUPPORTED);
      hdr_bytes.push_back(8'h80);
      hdr_bytes.push_back(8'h00);
      send_buffer();
      // illegal data size, all fields still reported
      push_word(VERSION_SUPPORTED);
      push_varint(64'd3, VARINT_PLAIN);
      push_varint(64'd2, VARINT_PLAIN);
      push_varint(64'd1000, VARINT_PLAIN);
      send_buffer();
      // legal data size, illegal id size
      push_word(VERSION_SUPPORTED);
      push_varint(64'd16, VARINT_PLAIN);
      push_varint(64'd0, VARINT_PLAIN);
      push_varint(64'd7, VARINT_PLAIN);
      send_buffer();
      // buffer ends inside a varint
      push_word(VERSION_SUPPORTED);
      push_varint(64'd8, VARINT_PLAIN);
      hdr_bytes.push_back(8'h81);
      send_buffer();

      base = bytes_sent;
      while (bytes_sent - base < RANDOM_BYTES) begin
         if (bytes_sent - base >= CALM_AFTER)
            calm = 1'b1;
         build_random_buffer();
         send_buffer();
      end
      req_chan.valid <= 1'b0;

      // drain: wait until every expected result has been checked
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d header bytes, checked %0d results", bytes_sent, results_checked);
      $display("status codes seen (bit per code, ok at bit 0): %b, mismatches: %0d",
               statuses_seen, fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
